### hdl/dgpd_pkg.sv
// ----------------------------------------------------------------------------
// dgpd_pkg: shared types and constants for the drive and gimbal PD step core
// Register indexes, reset values, field widths and the stage load bundle.
// ----------------------------------------------------------------------------
package dgpd_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PAN_DEADZONE    = 3'd0,
    CFG_TILT_DEADZONE   = 3'd1,
    CFG_PAN_RATE_LIMIT  = 3'd2,
    CFG_TILT_RATE_LIMIT = 3'd3,
    CFG_TURN_THRESHOLD  = 3'd4,
    CFG_TURN_SPEED      = 3'd5,
    CFG_DUTY_FULL_SCALE = 3'd6
  } cfg_reg_t;

  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [9:0]  PAN_DEADZONE_RST    = 10'd15;
  localparam logic [9:0]  TILT_DEADZONE_RST   = 10'd10;
  localparam logic [15:0] PAN_RATE_LIMIT_RST  = 16'd5000;
  localparam logic [15:0] TILT_RATE_LIMIT_RST = 16'd5000;
  localparam logic [6:0]  TURN_THRESHOLD_RST  = 7'd80;
  localparam logic [6:0]  TURN_SPEED_RST      = 7'd90;
  localparam logic [19:0] DUTY_FULL_SCALE_RST = 20'd500000;

  // duty scaling: full stick magnitude and output ceiling
  localparam int          DUTY_DIVISOR = 127;
  localparam logic [27:0] DUTY_MAX     = 28'hFFF_FFFF;

  // per-stage load strobes, shared by every pipeline slice
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } stage_ld_t;

endpackage

### hdl/dgpd_duty.sv
// ----------------------------------------------------------------------------
// dgpd_duty: wheel direction and PWM duty pipeline (stages 2 to 5)
// duty = min(mult * full_scale * |speed| / 127, DUTY_MAX), divide by shift-add.
// ----------------------------------------------------------------------------
module dgpd_duty (
  input  logic               clk,
  input  dgpd_pkg::stage_ld_t ld,
  input  logic signed [8:0]  speed,
  input  logic [8:0]         mult,
  input  logic [19:0]        full_scale,
  output logic               forward,
  output logic [27:0]        duty
);
  import dgpd_pkg::*;

  logic [7:0]  mag;
  logic [16:0] prod_a;
  logic        fwd2, fwd3, fwd4;
  logic [36:0] prod_p;
  logic [36:0] prod_p4;
  logic [37:0] approx_sum;
  logic [30:0] quot4;
  logic [37:0] remainder;
  logic [30:0] quot_fix;
  logic [27:0] duty_next;

  assign mag = speed[8] ? 8'(-speed) : speed[7:0];

  // stage 2: multiplier times speed magnitude
  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      prod_a <= 17'(mult) * 17'(mag);
      fwd2   <= ~speed[8];
    end
  end

  // stage 3: times full scale
  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      prod_p <= 37'(prod_a) * 37'(full_scale);
      fwd3   <= fwd2;
    end
  end

  // stage 4: x/127 estimate, x*128/127 as a geometric series of shifts
  assign approx_sum = 38'(prod_p) + 38'(prod_p >> 7) + 38'(prod_p >> 14)
                    + 38'(prod_p >> 21) + 38'(prod_p >> 28) + 38'(prod_p >> 35);

  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      quot4   <= approx_sum[37:7];
      prod_p4 <= prod_p;
      fwd4    <= fwd3;
    end
  end

  // stage 5: estimate is low by at most one; fix up and saturate
  always_comb begin
    remainder = 38'(prod_p4) - {quot4, 7'b0} + 38'(quot4);
    quot_fix  = quot4 + 31'(remainder >= 38'(DUTY_DIVISOR));
    if (quot_fix > 31'(DUTY_MAX)) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = quot_fix[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld5) begin
      duty    <= duty_next;
      forward <= fwd4;
    end
  end

endmodule

### hdl/dgpd_pd_axis.sv
// ----------------------------------------------------------------------------
// dgpd_pd_axis: one gimbal axis PD step in tenths of a degree
// Error with deadzone, drive = 11*e - previous e, rate limit with fault.
// ----------------------------------------------------------------------------
module dgpd_pd_axis (
  input  logic                clk,
  input  logic                rst,
  input  dgpd_pkg::stage_ld_t ld,
  input  logic [7:0]          target,
  input  logic [15:0]         measured,
  input  logic [9:0]          deadzone,
  input  logic [15:0]         limit,
  output logic                positive,
  output logic [15:0]         rate,
  output logic                fault
);
  import dgpd_pkg::*;

  logic [11:0]        target_x10;
  logic signed [17:0] err_raw;
  logic [16:0]        err_mag;
  logic signed [17:0] err1;
  logic signed [17:0] prev_err;
  logic signed [20:0] err_ext;
  logic signed [20:0] drive;
  logic [19:0]        drive_mag;
  logic               over;
  logic               pos2, pos3, pos4;
  logic [15:0]        rate2, rate3, rate4;
  logic               fault2, fault3, fault4;

  // stage 1: error in tenths, zeroed inside the deadzone
  assign target_x10 = 12'({target, 3'b000}) + 12'({target, 1'b0});
  assign err_raw    = $signed({6'b0, target_x10}) - $signed({2'b0, measured});
  assign err_mag    = err_raw[17] ? 17'(-err_raw) : 17'(err_raw);

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      err1 <= (err_mag < 17'(deadzone)) ? '0 : err_raw;
    end
  end

  // stage 2: PD drive and limit check
  assign err_ext   = 21'(err1);
  assign drive     = (err_ext <<< 3) + (err_ext <<< 1) + err_ext - 21'(prev_err);
  assign drive_mag = drive[20] ? 20'(-drive) : 20'(drive);
  assign over      = drive_mag > 20'(limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
    end else if (ld.ld2) begin
      prev_err <= err1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      pos2   <= ~drive[20];
      rate2  <= over ? '0 : drive_mag[15:0];
      fault2 <= over;
    end
  end

  // stages 3 to 5: ride along with the duty pipeline
  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      pos3   <= pos2;
      rate3  <= rate2;
      fault3 <= fault2;
    end
    if (ld.ld4) begin
      pos4   <= pos3;
      rate4  <= rate3;
      fault4 <= fault3;
    end
    if (ld.ld5) begin
      positive <= pos4;
      rate     <= rate4;
      fault    <= fault4;
    end
  end

endmodule

### hdl/drive_and_gimbal_pd_step_core.sv
// ----------------------------------------------------------------------------
// drive_and_gimbal_pd_step_core: control tick to wheel duty and gimbal rates
// Input request per tick; one result per request, same order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one control tick per request.
//   Output channel out_valid/out_stall carries the wheel directions and
//   duties plus the pan/tilt direction, rate and fault for that tick.
//   Acceptance loads stage 1; results pass stages 2 to 5 to out_valid.
//   One request is taken per cycle while in_stall is low, through the
//   five-stage pipeline (stage 3 holds the 17x20 duty multiply).
//   When the receiver stalls, the output stage holds its result and earlier
//   stages keep filling until the pipeline is full; then in_stall rises.
//   Reset clears all pipeline valids, the held targets and previous errors,
//   sets the speed multiplier to one and loads the register defaults.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect on the
//   next edge; an index of 7 is ignored. Write only while the pipe is empty.
// ----------------------------------------------------------------------------
module drive_and_gimbal_pd_step_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [dgpd_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          packet_valid,
  input  logic signed [7:0]             stick_x,
  input  logic signed [7:0]             stick_y,
  input  logic [7:0]                    pan_target,
  input  logic [7:0]                    tilt_target,
  input  logic [7:0]                    mode_code,
  input  logic [15:0]                   heading_raw,
  input  logic [15:0]                   roll_raw,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          right_forward,
  output logic                          left_forward,
  output logic [27:0]                   right_duty,
  output logic [27:0]                   left_duty,
  output logic                          pan_positive,
  output logic                          tilt_positive,
  output logic [15:0]                   pan_rate,
  output logic [15:0]                   tilt_rate,
  output logic                          pan_fault,
  output logic                          tilt_fault
);
  import dgpd_pkg::*;

  // configuration registers
  logic [9:0]  pan_deadzone, tilt_deadzone;
  logic [15:0] pan_rate_limit, tilt_rate_limit;
  logic [6:0]  turn_threshold, turn_speed;
  logic [19:0] duty_full_scale;

  // tick state
  logic [8:0]  speed_multiplier;
  logic [7:0]  held_pan_target, held_tilt_target;

  // pipeline control
  logic        v1, v2, v3, v4, v5;
  logic        rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  stage_ld_t   ld;

  // stage 1 datapath
  logic [7:0]        pan_tgt_next, tilt_tgt_next;
  logic [8:0]        mult_next;
  logic signed [8:0] sx9, sy9, thr9, ts9;
  logic signed [8:0] rs_next, ls_next;
  logic signed [8:0] rs1, ls1;
  logic [8:0]        mult1;

  // config write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_deadzone    <= PAN_DEADZONE_RST;
      tilt_deadzone   <= TILT_DEADZONE_RST;
      pan_rate_limit  <= PAN_RATE_LIMIT_RST;
      tilt_rate_limit <= TILT_RATE_LIMIT_RST;
      turn_threshold  <= TURN_THRESHOLD_RST;
      turn_speed      <= TURN_SPEED_RST;
      duty_full_scale <= DUTY_FULL_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PAN_DEADZONE:    pan_deadzone    <= cfg_data[9:0];
        CFG_TILT_DEADZONE:   tilt_deadzone   <= cfg_data[9:0];
        CFG_PAN_RATE_LIMIT:  pan_rate_limit  <= cfg_data[15:0];
        CFG_TILT_RATE_LIMIT: tilt_rate_limit <= cfg_data[15:0];
        CFG_TURN_THRESHOLD:  turn_threshold  <= cfg_data[6:0];
        CFG_TURN_SPEED:      turn_speed      <= cfg_data[6:0];
        CFG_DUTY_FULL_SCALE: duty_full_scale <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // stall chain: a stage takes a request when empty or when it moves on
  always_comb begin
    rdy6      = ~out_stall;
    rdy5      = ~v5 | rdy6;
    rdy4      = ~v4 | rdy5;
    rdy3      = ~v3 | rdy4;
    rdy2      = ~v2 | rdy3;
    rdy1      = ~v1 | rdy2;
    ld.ld1    = in_valid & rdy1;
    ld.ld2    = v1 & rdy2;
    ld.ld3    = v2 & rdy3;
    ld.ld4    = v3 & rdy4;
    ld.ld5    = v4 & rdy5;
  end

  assign in_stall  = ~rdy1;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= ld.ld1 | (v1 & ~rdy2);
      v2 <= ld.ld2 | (v2 & ~rdy3);
      v3 <= ld.ld3 | (v3 & ~rdy4);
      v4 <= ld.ld4 | (v4 & ~rdy5);
      v5 <= ld.ld5 | (v5 & ~rdy6);
    end
  end

  // stick mix: spin in place beyond the threshold, else follow stick y; zero speed without a packet
  always_comb begin
    sx9  = 9'(stick_x);
    sy9  = 9'(stick_y);
    thr9 = $signed({2'b0, turn_threshold});
    ts9  = $signed({2'b0, turn_speed});
    rs_next       = '0;
    ls_next       = '0;
    pan_tgt_next  = held_pan_target;
    tilt_tgt_next = held_tilt_target;
    mult_next     = speed_multiplier;
    if (packet_valid) begin
      pan_tgt_next  = pan_target;
      tilt_tgt_next = tilt_target;
      mult_next     = 9'(mode_code) + 9'd1;
      if (sx9 > thr9) begin
        rs_next = -ts9;
        ls_next = ts9;
      end else if (sx9 < -thr9) begin
        rs_next = ts9;
        ls_next = -ts9;
      end else begin
        rs_next = sy9;
        ls_next = sy9;
      end
    end
  end

  // held packet state updates on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_multiplier <= 9'd1;
      held_pan_target  <= '0;
      held_tilt_target <= '0;
    end else if (ld.ld1) begin
      speed_multiplier <= mult_next;
      held_pan_target  <= pan_tgt_next;
      held_tilt_target <= tilt_tgt_next;
    end
  end

  // stage 1 registers for the wheel path
  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      rs1   <= rs_next;
      ls1   <= ls_next;
      mult1 <= mult_next;
    end
  end

  // wheel duty pipelines
  dgpd_duty u_right_duty (
    .clk        (clk),
    .ld         (ld),
    .speed      (rs1),
    .mult       (mult1),
    .full_scale (duty_full_scale),
    .forward    (right_forward),
    .duty       (right_duty)
  );

  dgpd_duty u_left_duty (
    .clk        (clk),
    .ld         (ld),
    .speed      (ls1),
    .mult       (mult1),
    .full_scale (duty_full_scale),
    .forward    (left_forward),
    .duty       (left_duty)
  );

  // gimbal PD axes
  dgpd_pd_axis u_pan (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .target   (pan_tgt_next),
    .measured (heading_raw),
    .deadzone (pan_deadzone),
    .limit    (pan_rate_limit),
    .positive (pan_positive),
    .rate     (pan_rate),
    .fault    (pan_fault)
  );

  dgpd_pd_axis u_tilt (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .target   (tilt_tgt_next),
    .measured (roll_raw),
    .deadzone (tilt_deadzone),
    .limit    (tilt_rate_limit),
    .positive (tilt_positive),
    .rate     (tilt_rate),
    .fault    (tilt_fault)
  );

endmodule
